// File: hw/rtl/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared types and codes for the preferential attachment picker.
// ----------------------------------------------------------------------------
package pap_pkg;

   // Fixed field widths of the ports
   localparam int unsigned NODE_CNT_W = 11;
   localparam int unsigned EDGE_CFG_W = 4;
   localparam int unsigned OUT_NODE_W = 10;
   localparam int unsigned WORD_W     = 32;

   // Register indexes on the CSR port (byte address bit 2)
   localparam logic REG_NODE_COUNT     = 1'b0;
   localparam logic REG_EDGES_PER_NODE = 1'b1;

   localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 11'd1024;
   localparam logic [EDGE_CFG_W-1:0] EDGES_RST      = 4'd2;

   typedef enum logic [1:0] {
      ST_SEED   = 2'd0,
      ST_EDGE   = 2'd1,
      ST_REJECT = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_WALK,
      S_BUMP,
      S_SETNEW,
      S_FINISH
   } fsm_type;

endpackage

// File: hw/rtl/preferential_attachment_picker_top.sv
// ----------------------------------------------------------------------------
// preferential_attachment_picker_top
// Grows a scale-free graph by preferential attachment, one draw per transfer.
// ----------------------------------------------------------------------------
// Each request transfer yields exactly one response transfer. A seed node, a
// finished graph or an empty total goes from S_IDLE straight to S_FINISH. A
// draw for a later node scales the random word by the degree total (one
// multiply), then walks the degree memory from node 0, one read per cycle
// through its single read port. A picked node then passes S_BUMP (and S_SETNEW
// when the pick completes the node, for the new node's degree write), and a
// rejected draw walks all current nodes before S_FINISH. The degree table
// lives in a one-port-read, one-port-write synchronous memory; the chosen
// list, total, node index and pick count sit in flops. The response register
// lets the next request enter while a result still waits on rsp_stall.
module preferential_attachment_picker_top
   import pap_pkg::*;
#(
   parameter int unsigned MAX_NODES = 1024,
   parameter int unsigned MAX_EDGES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [WORD_W-1:0]     req_random_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [OUT_NODE_W-1:0] rsp_new_node,
   output logic [OUT_NODE_W-1:0] rsp_target_node,
   output logic                  rsp_node_complete,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int unsigned LW  = $clog2(MAX_NODES + 1);
   localparam int unsigned CNW = (LW > NODE_CNT_W) ? LW : NODE_CNT_W;
   localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
   localparam int unsigned MW  = (EW > EDGE_CFG_W) ? EW : EDGE_CFG_W;
   localparam int unsigned DW  = $clog2(MAX_NODES + MAX_EDGES + 1);
   localparam int unsigned TW  = $clog2(MAX_NODES * (2 * MAX_EDGES + 1) + 1);

   // Configuration
   logic [NODE_CNT_W-1:0] node_count_ff;
   logic [EDGE_CFG_W-1:0] edges_ff;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_EDGES_PER_NODE)
                       ? {{(32-EDGE_CFG_W){1'b0}}, edges_ff}
                       : {{(32-NODE_CNT_W){1'b0}}, node_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         edges_ff      <= EDGES_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_NODE_COUNT) begin
            node_count_ff <= csr_pwdata[NODE_CNT_W-1:0];
         end else begin
            edges_ff <= csr_pwdata[EDGE_CFG_W-1:0];
         end
      end
   end

   // Clamp the registers to the sizes this instance holds; an edge count of zero counts as one
   logic [CNW-1:0] limit;
   logic [MW-1:0]  m_eff;

   always_comb begin
      if (CNW'(node_count_ff) > CNW'(MAX_NODES)) limit = CNW'(MAX_NODES);
      else                                       limit = CNW'(node_count_ff);
      if (edges_ff == '0)                           m_eff = MW'(1);
      else if (MW'(edges_ff) > MW'(MAX_EDGES))      m_eff = MW'(MAX_EDGES);
      else                                          m_eff = MW'(edges_ff);
   end

   // Growth state
   fsm_type        state_ff, state_in;
   logic [LW-1:0]  cur_ff;
   logic [TW-1:0]  total_ff;
   logic [EW-1:0]  picks_ff;
   logic [NW-1:0]  chosen_ff [MAX_EDGES];
   logic [WORD_W-1:0] word_ff;
   logic [TW-1:0]  ran_ff;
   logic [TW-1:0]  sum_ff;
   logic [LW-1:0]  raddr_ff;
   logic           rd_vld_ff;
   logic [LW-1:0]  rd_idx_ff;
   logic [DW-1:0]  rdata_ff;
   logic [NW-1:0]  tgt_ff;
   logic [DW-1:0]  tdeg_ff;

   // Pending result
   status_type     res_status_ff;
   logic [NW-1:0]  res_new_ff;
   logic [NW-1:0]  res_tgt_ff;
   logic           res_cmp_ff;

   // Output register
   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   logic [NW-1:0]  rsp_new_ff;
   logic [NW-1:0]  rsp_tgt_ff;
   logic           rsp_cmp_ff;

   // Degree memory
   logic [DW-1:0]  deg_mem [MAX_NODES];
   logic           mem_we;
   logic [NW-1:0]  mem_waddr;
   logic [DW-1:0]  mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         deg_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= deg_mem[raddr_ff[NW-1:0]];
   end

   // Decision terms
   logic           req_xfer;
   logic           is_done, is_seed, is_empty;
   logic [TW-1:0]  nsum;
   logic           in_list;
   logic           hit;
   logic           last_rd;
   logic [EW:0]    picks_inc;
   logic           completes;
   logic           out_free;
   logic [WORD_W+TW-1:0] prod;

   assign req_xfer  = req_valid && !req_stall;
   assign is_done   = CNW'(cur_ff) >= limit;
   assign is_seed   = CNW'(cur_ff) <= CNW'(m_eff);
   assign is_empty  = (total_ff == '0);
   assign nsum      = sum_ff + TW'(rdata_ff);
   assign last_rd   = (rd_idx_ff == cur_ff - LW'(1));
   assign picks_inc = (EW+1)'(picks_ff) + (EW+1)'(1);
   assign completes = (MW+1)'(picks_inc) >= (MW+1)'(m_eff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign prod      = (WORD_W+TW)'(word_ff) * (WORD_W+TW)'(total_ff);

   always_comb begin
      in_list = 1'b0;
      for (int k = 0; k < MAX_EDGES; k++) begin
         if ((EW'(k) < picks_ff) && (chosen_ff[k] == rd_idx_ff[NW-1:0])) begin
            in_list = 1'b1;
         end
      end
   end

   assign hit = rd_vld_ff && (nsum > ran_ff) && !in_list;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (is_done || is_seed || is_empty) state_in = S_FINISH;
               else                                state_in = S_SCALE;
            end
         end
         S_SCALE:  state_in = S_WALK;
         S_WALK: begin
            if (hit)                         state_in = S_BUMP;
            else if (rd_vld_ff && last_rd)   state_in = S_FINISH;
         end
         S_BUMP:   state_in = completes ? S_SETNEW : S_FINISH;
         S_SETNEW: state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: request stall and memory writes
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = cur_ff[NW-1:0];
      mem_wdata = DW'(1);
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            mem_we    = req_xfer && !is_done && is_seed;
         end
         S_BUMP: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = tdeg_ff + DW'(1);
         end
         S_SETNEW: begin
            mem_we    = 1'b1;
            mem_wdata = DW'(m_eff);
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         total_ff     <= '0;
         picks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         // mark the read data valid while nodes remain
         rd_vld_ff <= (state_ff == S_WALK) && !hit && (raddr_ff < cur_ff);
         if (state_ff == S_FINISH && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)  rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_xfer && !is_done && is_seed) begin
                  // place a seed, drop any partial picks
                  total_ff <= total_ff + TW'(1);
                  cur_ff   <= cur_ff + LW'(1);
                  picks_ff <= '0;
               end
            end
            S_BUMP: begin
               total_ff <= total_ff + TW'(1);
               picks_ff <= picks_inc[EW-1:0];
            end
            S_SETNEW: begin
               total_ff <= total_ff + TW'(m_eff);
               cur_ff   <= cur_ff + LW'(1);
               picks_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            word_ff    <= req_random_word;
            res_tgt_ff <= '0;
            if (is_done) begin
               res_status_ff <= ST_DONE;
               res_new_ff    <= '0;
               res_cmp_ff    <= 1'b0;
            end else if (is_seed) begin
               res_status_ff <= ST_SEED;
               res_new_ff    <= cur_ff[NW-1:0];
               res_cmp_ff    <= 1'b1;
            end else begin
               res_status_ff <= ST_REJECT;
               res_new_ff    <= cur_ff[NW-1:0];
               res_cmp_ff    <= 1'b0;
            end
         end
         S_SCALE: begin
            ran_ff   <= prod[WORD_W+TW-1:WORD_W];
            sum_ff   <= '0;
            raddr_ff <= '0;
         end
         S_WALK: begin
            raddr_ff  <= raddr_ff + LW'(1);
            rd_idx_ff <= raddr_ff;
            if (rd_vld_ff) sum_ff <= nsum;
            if (hit) begin
               tgt_ff  <= rd_idx_ff[NW-1:0];
               tdeg_ff <= rdata_ff;
            end
         end
         S_BUMP: begin
            for (int k = 0; k < MAX_EDGES; k++) begin
               if (EW'(k) == picks_ff) chosen_ff[k] <= tgt_ff;
            end
            res_status_ff <= ST_EDGE;
            res_tgt_ff    <= tgt_ff;
            res_cmp_ff    <= completes;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_new_ff    <= res_new_ff;
               rsp_tgt_ff    <= res_tgt_ff;
               rsp_cmp_ff    <= res_cmp_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_new_node      = OUT_NODE_W'(rsp_new_ff);
   assign rsp_target_node   = OUT_NODE_W'(rsp_tgt_ff);
   assign rsp_node_complete = rsp_cmp_ff;

   // The degree total only grows between resets
   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      ##1 total_ff >= $past(total_ff))
      else $error("degree total decreased");

   // Completing a node advances the node index by one
   a_node_advance: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SETNEW |=> cur_ff == $past(cur_ff) + LW'(1))
      else $error("node index did not advance");

   // The node index never passes the table depth
   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      LW'(MAX_NODES) >= cur_ff)
      else $error("node index out of range");

endmodule
